// File: src/grid_line_of_sight_march_top_macros.svh
// Assertion macros for the checker file of the line-of-sight block.
// Depends on nothing; include by bare file name.
`ifndef GRID_LINE_OF_SIGHT_MARCH_TOP_MACROS_SVH
`define GRID_LINE_OF_SIGHT_MARCH_TOP_MACROS_SVH

// check a property on every rising edge outside reset
`define GLOS_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error("glos check failed");

// check an implication that spans into the next cycle
`define GLOS_ASSERT_NEXT(lbl, clk, rstn, cond, conseq) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (conseq)) else $error("glos check failed");

`endif

// File: src/glos_pkg.sv
// Package for the grid line-of-sight march block: sizes, register indexes,
// sequencer states. Depends on nothing.
package glos_pkg;

	localparam int MAP_CELLS  = 4096;
	localparam int MAP_AW     = 12;
	localparam int COORD_BITS = 16;

	localparam int IN_DATA_W  = 80;
	localparam int OUT_DATA_W = 24;

	localparam logic [12:0] MAP_WIDTH_RST  = 13'd64;
	localparam logic [12:0] MAP_HEIGHT_RST = 13'd64;
	localparam logic [7:0]  TILE_SIZE_RST  = 8'd32;

	typedef enum logic [1:0] {
		REG_MAP_WIDTH  = 2'd0,
		REG_MAP_HEIGHT = 2'd1,
		REG_TILE_SIZE  = 2'd2,
		REG_NONE       = 2'd3
	} reg_idx_t;

	typedef enum logic [0:0] {
		ACT_WRITE = 1'b0,
		ACT_CAST  = 1'b1
	} action_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQX,
		ST_SQY,
		ST_SUM,
		ST_SQRT,
		ST_LEN,
		ST_DIVX,
		ST_DIVY,
		ST_TDX,
		ST_TDY,
		ST_MUL,
		ST_ADR,
		ST_EVAL,
		ST_DONE
	} state_t;

endpackage

// File: src/glos_vmap.sv
// Void map storage: one bit per tile cell, one write and one registered read port.
// Depends on glos_pkg.
module glos_vmap (
	input  logic                      clk,
	input  logic                      wr_en,
	input  logic [glos_pkg::MAP_AW-1:0] wr_addr,
	input  logic                      wr_data,
	input  logic                      rd_en,
	input  logic [glos_pkg::MAP_AW-1:0] rd_addr,
	output logic                      rd_data
);

	logic mem [glos_pkg::MAP_CELLS];
	logic rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_q;

endmodule

// File: src/grid_line_of_sight_march_top.sv
// Top level of the grid line-of-sight march block: sequencer, shared subtract
// and multiply unit, position tracking. Depends on glos_pkg and glos_vmap.
//
// Usage: items arrive on s_axis (tuser = action). A write item (action 0)
// updates one bit of the void map and gives no result. A cast item
// (action 1) gives exactly one result on m_axis: blocked and hit distance.
// Configuration writes use cfg_valid/cfg_ready/cfg_index/cfg_data; cfg_ready is
// always high, and writes are meant for idle periods.
// A cast runs in order: squares and sum, the root, the length, the two direction
// divides, the two tile divides, then one step loop per position checked
// (multiply, map read, evaluate), then the output register; a zero-length cast
// goes from the sum straight to the output register. The step loop around the map
// read port sets the per-pixel rate; the shared subtractor sets the setup time.
// s_axis_tready is high only while the sequencer is idle. A finished result
// waits in the output register; the next item is taken meanwhile, and a later
// cast holds its result until the receiver drains the register.
// Reset (arst_n low) clears the sequencer and output valid and restores the
// configuration defaults; the void map keeps undefined contents until written.
module grid_line_of_sight_march_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// cell_index[11:0], cell_void[12], start_x[28:13], start_y[44:29],
	// end_x[60:45], end_y[76:61], zero fill
	input  logic [glos_pkg::IN_DATA_W-1:0]      s_axis_tdata,
	// action[0]
	input  logic                                s_axis_tuser,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// blocked[0], hit_distance[17:1], zero fill
	output logic [glos_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [1:0]                          cfg_index,
	input  logic [12:0]                         cfg_data
);

	glos_pkg::state_t state_q, state_d;

	logic [12:0] map_width_q, map_height_q;
	logic [7:0]  tile_size_q;
	logic [7:0]  ts_eff;

	logic [15:0] sx_q, sy_q, adx_q, ady_q;
	logic        sgx_q, sgy_q;
	logic [33:0] prod_q;
	logic [49:0] op_q;
	logic [41:0] rem_q, dv_q;
	logic [24:0] quo_q, len_q;
	logic [4:0]  cnt_q;
	logic [16:0] steps_q, i_q;
	logic [17:0] vx_q, vy_q;
	logic [35:0] px_q, py_q;
	logic [17:0] cx_q, cy_q;
	logic [7:0]  mx_q, my_q;
	logic        oob_q;
	logic        res_blk_q;
	logic [16:0] res_dist_q;
	logic        out_valid_q;
	logic [glos_pkg::OUT_DATA_W-1:0] out_data_q;

	logic        in_acc, is_cast;
	logic [16:0] dxs, dys;
	logic [17:0] mul_a;
	logic [15:0] mul_b;
	logic [33:0] mul_p;
	logic [41:0] sub_a, sub_b;
	logic [42:0] sub_d;
	logic        borrow;
	logic [24:0] qn;
	logic [41:0] rn;
	logic [33:0] dsum;
	logic [34:0] idx;
	logic        oob;
	logic        map_rd;
	logic        map_bit;
	logic        out_load;
	logic [35:0] npx, npy;
	logic [17:0] vx_n, vy_n;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (state_q == glos_pkg::ST_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign is_cast       = (s_axis_tuser == glos_pkg::ACT_CAST);
	assign ts_eff        = (tile_size_q == 8'd0) ? 8'd1 : tile_size_q;

	assign dxs = {1'b0, s_axis_tdata[60:45]} - {1'b0, s_axis_tdata[28:13]};
	assign dys = {1'b0, s_axis_tdata[76:61]} - {1'b0, s_axis_tdata[44:29]};

	always_comb begin
		mul_a = {2'b00, adx_q};
		mul_b = adx_q;
		case (state_q)
			glos_pkg::ST_SQY: begin
				mul_a = {2'b00, ady_q};
				mul_b = ady_q;
			end
			glos_pkg::ST_MUL: begin
				mul_a = cy_q;
				mul_b = {3'b000, map_width_q};
			end
			default: begin
				mul_a = {2'b00, adx_q};
				mul_b = adx_q;
			end
		endcase
	end
	assign mul_p = mul_a * mul_b;

	always_comb begin
		if (state_q == glos_pkg::ST_SQRT) begin
			sub_a = {rem_q[39:0], op_q[49:48]};
			sub_b = {15'd0, quo_q, 2'b01};
		end else begin
			sub_a = rem_q;
			sub_b = dv_q;
		end
	end
	assign sub_d  = {1'b0, sub_a} - {1'b0, sub_b};
	assign borrow = sub_d[42];
	assign qn     = {quo_q[23:0], ~borrow};
	assign rn     = borrow ? sub_a : sub_d[41:0];

	assign dsum = op_q[33:0] + prod_q;
	assign idx  = {1'b0, prod_q} + {17'd0, cx_q};
	assign oob  = px_q[35] || py_q[35]
		|| (cx_q >= {5'd0, map_width_q}) || (cy_q >= {5'd0, map_height_q})
		|| (idx >= 35'(glos_pkg::MAP_CELLS));
	assign map_rd = (state_q == glos_pkg::ST_ADR);

	assign vx_n = sgx_q ? 18'(-{1'b0, qn[16:0]}) : {1'b0, qn[16:0]};
	assign vy_n = sgy_q ? 18'(-{1'b0, qn[16:0]}) : {1'b0, qn[16:0]};
	assign npx  = px_q + {{18{vx_q[17]}}, vx_q};
	assign npy  = py_q + {{18{vy_q[17]}}, vy_q};

	glos_vmap u_vmap (
		.clk     (clk),
		.wr_en   (in_acc && !is_cast),
		.wr_addr (s_axis_tdata[11:0]),
		.wr_data (s_axis_tdata[12]),
		.rd_en   (map_rd),
		.rd_addr (idx[glos_pkg::MAP_AW-1:0]),
		.rd_data (map_bit)
	);

	assign out_load = (state_q == glos_pkg::ST_DONE) && (!out_valid_q || m_axis_tready);

	always_comb begin
		state_d = state_q;
		case (state_q)
			glos_pkg::ST_IDLE: begin
				if (in_acc && is_cast) state_d = glos_pkg::ST_SQX;
			end
			glos_pkg::ST_SQX: state_d = glos_pkg::ST_SQY;
			glos_pkg::ST_SQY: state_d = glos_pkg::ST_SUM;
			glos_pkg::ST_SUM: begin
				state_d = (dsum == 34'd0) ? glos_pkg::ST_DONE : glos_pkg::ST_SQRT;
			end
			glos_pkg::ST_SQRT: begin
				if (cnt_q == 5'd1) state_d = glos_pkg::ST_LEN;
			end
			glos_pkg::ST_LEN: state_d = glos_pkg::ST_DIVX;
			glos_pkg::ST_DIVX: begin
				if (cnt_q == 5'd1) state_d = glos_pkg::ST_DIVY;
			end
			glos_pkg::ST_DIVY: begin
				if (cnt_q == 5'd1) state_d = glos_pkg::ST_TDX;
			end
			glos_pkg::ST_TDX: begin
				if (cnt_q == 5'd1) state_d = glos_pkg::ST_TDY;
			end
			glos_pkg::ST_TDY: begin
				if (cnt_q == 5'd1) state_d = glos_pkg::ST_MUL;
			end
			glos_pkg::ST_MUL: state_d = glos_pkg::ST_ADR;
			glos_pkg::ST_ADR: state_d = glos_pkg::ST_EVAL;
			glos_pkg::ST_EVAL: begin
				if (oob_q || map_bit || (i_q + 17'd1 == steps_q)) begin
					state_d = glos_pkg::ST_DONE;
				end else begin
					state_d = glos_pkg::ST_MUL;
				end
			end
			glos_pkg::ST_DONE: begin
				if (out_load) state_d = glos_pkg::ST_IDLE;
			end
			default: state_d = glos_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= glos_pkg::ST_IDLE;
			out_valid_q  <= 1'b0;
			map_width_q  <= glos_pkg::MAP_WIDTH_RST;
			map_height_q <= glos_pkg::MAP_HEIGHT_RST;
			tile_size_q  <= glos_pkg::TILE_SIZE_RST;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				case (glos_pkg::reg_idx_t'(cfg_index))
					glos_pkg::REG_MAP_WIDTH:  map_width_q  <= cfg_data;
					glos_pkg::REG_MAP_HEIGHT: map_height_q <= cfg_data;
					glos_pkg::REG_TILE_SIZE:  tile_size_q  <= cfg_data[7:0];
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= {6'd0, res_dist_q, res_blk_q};
		end
		case (state_q)
			glos_pkg::ST_IDLE: begin
				sx_q  <= s_axis_tdata[28:13];
				sy_q  <= s_axis_tdata[44:29];
				sgx_q <= dxs[16];
				sgy_q <= dys[16];
				adx_q <= dxs[16] ? 16'(-dxs) : dxs[15:0];
				ady_q <= dys[16] ? 16'(-dys) : dys[15:0];
			end
			glos_pkg::ST_SQX: prod_q <= mul_p;
			glos_pkg::ST_SQY: begin
				op_q   <= {16'd0, prod_q};
				prod_q <= mul_p;
			end
			glos_pkg::ST_SUM: begin
				op_q       <= {dsum[33:0], 16'd0};
				rem_q      <= '0;
				quo_q      <= '0;
				cnt_q      <= 5'd25;
				res_blk_q  <= 1'b0;
				res_dist_q <= '0;
			end
			glos_pkg::ST_SQRT: begin
				rem_q <= rn;
				quo_q <= qn;
				op_q  <= {op_q[47:0], 2'b00};
				cnt_q <= cnt_q - 5'd1;
			end
			glos_pkg::ST_LEN: begin
				len_q   <= quo_q;
				steps_q <= quo_q[24:8] + {16'd0, (rem_q != 42'd0)};
				rem_q   <= {2'b00, adx_q, 24'd0};
				dv_q    <= {1'b0, quo_q, 16'd0};
				quo_q   <= '0;
				cnt_q   <= 5'd17;
			end
			glos_pkg::ST_DIVX, glos_pkg::ST_DIVY, glos_pkg::ST_TDX, glos_pkg::ST_TDY: begin
				rem_q <= rn;
				quo_q <= qn;
				dv_q  <= {1'b0, dv_q[41:1]};
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					quo_q <= '0;
					case (state_q)
						glos_pkg::ST_DIVX: begin
							vx_q  <= vx_n;
							rem_q <= {2'b00, ady_q, 24'd0};
							dv_q  <= {1'b0, len_q, 16'd0};
							cnt_q <= 5'd17;
						end
						glos_pkg::ST_DIVY: begin
							vy_q  <= vy_n;
							rem_q <= {26'd0, sx_q};
							dv_q  <= {19'd0, ts_eff, 15'd0};
							cnt_q <= 5'd16;
						end
						glos_pkg::ST_TDX: begin
							cx_q  <= {2'b00, qn[15:0]};
							mx_q  <= rn[7:0];
							rem_q <= {26'd0, sy_q};
							dv_q  <= {19'd0, ts_eff, 15'd0};
							cnt_q <= 5'd16;
						end
						default: begin
							cy_q <= {2'b00, qn[15:0]};
							my_q <= rn[7:0];
							px_q <= {4'd0, sx_q, 16'd0};
							py_q <= {4'd0, sy_q, 16'd0};
							i_q  <= '0;
						end
					endcase
				end
			end
			glos_pkg::ST_MUL: prod_q <= mul_p;
			glos_pkg::ST_ADR: oob_q <= oob;
			glos_pkg::ST_EVAL: begin
				if (oob_q || map_bit) begin
					res_blk_q  <= 1'b1;
					res_dist_q <= i_q;
				end else begin
					i_q  <= i_q + 17'd1;
					px_q <= npx;
					py_q <= npy;
					if (npx[35:16] != px_q[35:16]) begin
						if (vx_q[17]) begin
							if (mx_q == 8'd0) begin
								mx_q <= ts_eff - 8'd1;
								cx_q <= cx_q - 18'd1;
							end else begin
								mx_q <= mx_q - 8'd1;
							end
						end else if (mx_q == ts_eff - 8'd1) begin
							mx_q <= 8'd0;
							cx_q <= cx_q + 18'd1;
						end else begin
							mx_q <= mx_q + 8'd1;
						end
					end
					if (npy[35:16] != py_q[35:16]) begin
						if (vy_q[17]) begin
							if (my_q == 8'd0) begin
								my_q <= ts_eff - 8'd1;
								cy_q <= cy_q - 18'd1;
							end else begin
								my_q <= my_q - 8'd1;
							end
						end else if (my_q == ts_eff - 8'd1) begin
							my_q <= 8'd0;
							cy_q <= cy_q + 18'd1;
						end else begin
							my_q <= my_q + 8'd1;
						end
					end
				end
			end
			default: ;
		endcase
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule

// File: src/glos_chk.sv
// Port-level checker for the grid line-of-sight march top, bound to it below.
// Depends on grid_line_of_sight_march_top_macros.svh and glos_pkg.
`include "grid_line_of_sight_march_top_macros.svh"

module glos_chk (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_axis_tvalid,
	input logic                            s_axis_tready,
	input logic [glos_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	input logic                            s_axis_tuser,
	input logic                            m_axis_tvalid,
	input logic                            m_axis_tready,
	input logic [glos_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	input logic                            cfg_valid,
	input logic                            cfg_ready,
	input logic [1:0]                      cfg_index,
	input logic [12:0]                     cfg_data
);

	`GLOS_ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
	`GLOS_ASSERT(a_clear_dist, clk, arst_n, m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[17:1] == 17'd0)
	`GLOS_ASSERT_NEXT(a_cast_busy, clk, arst_n, s_axis_tvalid && s_axis_tready && s_axis_tuser, !s_axis_tready)
	`GLOS_ASSERT_NEXT(a_write_idle, clk, arst_n, s_axis_tvalid && s_axis_tready && !s_axis_tuser, s_axis_tready)

endmodule

bind grid_line_of_sight_march_top glos_chk u_glos_chk (.*);

// File: dv/grid_line_of_sight_march_top_tb.sv
// Testbench for grid_line_of_sight_march_top: random and directed map writes and ray casts,
// checked against a line-of-sight predictor kept in the bench. Depends on glos_pkg and the RTL.
`timescale 1ns / 1ps

module grid_line_of_sight_march_top_tb;

	typedef struct {
		glos_pkg::action_t act;
		logic [11:0] idx;
		logic        vd;
		logic [15:0] sx, sy, ex, ey;
	} ray_item_t;

	typedef struct {
		logic        blocked;
		logic [16:0] hit_dist;
	} sight_t;

	localparam int WATCHDOG_LIMIT = 1000000;
	// number of leading cells seeded with random void bits before the directed casts
	localparam int SEED_CELLS = 260;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [glos_pkg::IN_DATA_W-1:0] s_axis_tdata = '0;
	logic s_axis_tuser = 1'b0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [glos_pkg::OUT_DATA_W-1:0] m_axis_tdata;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [12:0] cfg_data = '0;

	ray_item_t pending_q[$];
	sight_t    sight_q[$];
	bit        vmap[glos_pkg::MAP_CELLS];
	longint    cur_width = 64, cur_height = 64, cur_tile = 32;
	int        snd_idle = 0, rcv_stall = 0;
	int        hold_req = 0, hold_seen = 0, hold_cnt = 0;
	int        cfg_count = 0;
	int        errors = 0;
	int        quiet = 0;
	bit        snd_taken = 0;

	grid_line_of_sight_march_top i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic longint int_sqrt(longint v);
		longint res, bt;
		res = 0;
		bt = longint'(1) << 62;
		while (bt > v)
			bt = bt >> 2;
		while (bt != 0) begin
			if (v >= res + bt) begin
				v = v - (res + bt);
				res = (res >> 1) + bt;
			end else begin
				res = res >> 1;
			end
			bt = bt >> 2;
		end
		return res;
	endfunction

	function automatic bit cell_is_blocking(longint px, longint py);
		longint ts, cx, cy, ci;
		ts = (cur_tile == 0) ? 1 : cur_tile;
		if (px < 0 || py < 0)
			return 1'b1;
		cx = (px >> 16) / ts;
		cy = (py >> 16) / ts;
		if (cx >= cur_width || cy >= cur_height)
			return 1'b1;
		ci = cy * cur_width + cx;
		if (ci >= glos_pkg::MAP_CELLS)
			return 1'b1;
		return vmap[ci];
	endfunction

	function automatic sight_t march_ray(ray_item_t it);
		sight_t r;
		longint dx, dy, d, s, steps, rem, frac, t, lq8, vx, vy, px, py;
		r.blocked = 1'b0;
		r.hit_dist = '0;
		dx = longint'(it.ex) - longint'(it.sx);
		dy = longint'(it.ey) - longint'(it.sy);
		d = dx * dx + dy * dy;
		if (d == 0)
			return r;
		s = int_sqrt(d);
		steps = s + ((s * s != d) ? 1 : 0);
		rem = (d - s * s) << 16;
		frac = 0;
		for (longint b = 128; b != 0; b = b >> 1) begin
			t = frac + b;
			if (512 * s * t + t * t <= rem)
				frac = t;
		end
		lq8 = s * 256 + frac;
		vx = ((dx < 0 ? -dx : dx) << 24) / lq8;
		vy = ((dy < 0 ? -dy : dy) << 24) / lq8;
		if (dx < 0)
			vx = -vx;
		if (dy < 0)
			vy = -vy;
		px = longint'(it.sx) * 65536;
		py = longint'(it.sy) * 65536;
		for (longint i = 0; i < steps; i++) begin
			if (cell_is_blocking(px, py)) begin
				r.blocked = 1'b1;
				r.hit_dist = i[16:0];
				return r;
			end
			px += vx;
			py += vy;
		end
		return r;
	endfunction

	// input side: hold the item until transferred, then advance
	always @(negedge clk) begin
		ray_item_t it;
		if (arst_n && (!s_axis_tvalid || snd_taken)) begin
			if (pending_q.size() > 0 && $urandom_range(99) >= snd_idle) begin
				it = pending_q[0];
				s_axis_tdata <= {3'b0, it.ey, it.ex, it.sy, it.sx, it.vd, it.idx};
				s_axis_tuser <= it.act;
				s_axis_tvalid <= 1'b1;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
		snd_taken = 0;
	end

	// output side: long hold-off on request, random stall otherwise
	always @(negedge clk) begin
		if (hold_req != hold_seen) begin
			hold_seen = hold_req;
			hold_cnt = 3000;
		end
		if (hold_cnt > 0) begin
			hold_cnt--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= rcv_stall);
		end
	end

	always @(posedge clk) begin
		ray_item_t it;
		sight_t exp_r;
		if (arst_n) begin
			quiet++;
			if (cfg_valid && cfg_ready) begin
				case (glos_pkg::reg_idx_t'(cfg_index))
					glos_pkg::REG_MAP_WIDTH:  cur_width = longint'(cfg_data);
					glos_pkg::REG_MAP_HEIGHT: cur_height = longint'(cfg_data);
					glos_pkg::REG_TILE_SIZE:  cur_tile = longint'(cfg_data[7:0]);
					default: ;
				endcase
				cfg_count++;
				quiet = 0;
			end
			if (s_axis_tvalid && s_axis_tready) begin
				it = pending_q.pop_front();
				if (it.act == glos_pkg::ACT_WRITE)
					vmap[it.idx] = it.vd;
				else
					sight_q.push_back(march_ray(it));
				snd_taken = 1;
				quiet = 0;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				quiet = 0;
				if (sight_q.size() == 0) begin
					$error("unexpected result transfer: %h", m_axis_tdata);
					errors++;
				end else begin
					exp_r = sight_q.pop_front();
					if (m_axis_tdata[0] !== exp_r.blocked) begin
						$error("blocked: expected %0d, got %0d", exp_r.blocked, m_axis_tdata[0]);
						errors++;
					end
					if (m_axis_tdata[17:1] !== exp_r.hit_dist) begin
						$error("hit_distance: expected %0d, got %0d", exp_r.hit_dist,
							m_axis_tdata[17:1]);
						errors++;
					end
				end
			end
			if (quiet >= WATCHDOG_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	task automatic write_reg(glos_pkg::reg_idx_t ri, logic [12:0] v);
		int seen;
		seen = cfg_count;
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= ri;
		cfg_data <= v;
		while (cfg_count == seen)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_map(logic [12:0] w, logic [12:0] h, logic [12:0] ts);
		write_reg(glos_pkg::REG_MAP_WIDTH, w);
		write_reg(glos_pkg::REG_MAP_HEIGHT, h);
		write_reg(glos_pkg::REG_TILE_SIZE, ts);
	endtask

	task automatic drain();
		while (pending_q.size() > 0 || sight_q.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	function automatic ray_item_t make_item(glos_pkg::action_t a, int sx, int sy, int ex,
		int ey);
		ray_item_t it;
		it.act = a;
		it.idx = 12'($urandom);
		it.vd = 1'($urandom);
		it.sx = 16'(sx);
		it.sy = 16'(sy);
		it.ex = 16'(ex);
		it.ey = 16'(ey);
		return it;
	endfunction

	function automatic int clamp_coord(int v);
		return (v < 0) ? 0 : (v > 65535) ? 65535 : v;
	endfunction

	function automatic ray_item_t random_item();
		ray_item_t it;
		int ext_x, ext_y, reach, sx, sy;
		longint ts;
		it = make_item(glos_pkg::ACT_CAST, int'($urandom), int'($urandom), int'($urandom),
			int'($urandom));
		if ($urandom_range(99) < 30) begin
			it.act = glos_pkg::ACT_WRITE;
			it.vd = ($urandom_range(99) < 20);
			return it;
		end
		ts = (cur_tile == 0) ? 1 : cur_tile;
		ext_x = clamp_coord(int'((cur_width + 1) * ts + 32));
		ext_y = clamp_coord(int'((cur_height + 1) * ts + 32));
		if ($urandom_range(99) < 85) begin
			reach = 150;
			sx = int'($urandom_range(ext_x));
			sy = int'($urandom_range(ext_y));
		end else begin
			reach = 1500;
			sx = int'($urandom_range(65535));
			sy = int'($urandom_range(65535));
		end
		it.sx = 16'(sx);
		it.sy = 16'(sy);
		it.ex = 16'(clamp_coord(sx + int'($urandom_range(2 * reach)) - reach));
		it.ey = 16'(clamp_coord(sy + int'($urandom_range(2 * reach)) - reach));
		return it;
	endfunction

	task automatic random_phase(int n, int idle, int stall);
		snd_idle = idle;
		rcv_stall = stall;
		repeat (n) pending_q.push_back(random_item());
		drain();
	endtask

	initial begin
		ray_item_t it;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int i = 0; i < SEED_CELLS; i++) begin
			it = make_item(glos_pkg::ACT_WRITE, 0, 0, 0, 0);
			it.idx = 12'(i);
			it.vd = ($urandom_range(99) < 8);
			pending_q.push_back(it);
		end
		drain();

		// directed: clear cells 0 to 7 of row 0, then block one cell on it
		for (int i = 0; i < 8; i++) begin
			it = make_item(glos_pkg::ACT_WRITE, 0, 0, 0, 0);
			it.idx = 12'(i);
			it.vd = 1'b0;
			pending_q.push_back(it);
		end
		pending_q.push_back(make_item(glos_pkg::ACT_CAST, 0, 5, 200, 5));
		it = make_item(glos_pkg::ACT_WRITE, 0, 0, 0, 0);
		it.idx = 12'd2;
		it.vd = 1'b1;
		pending_q.push_back(it);
		pending_q.push_back(make_item(glos_pkg::ACT_CAST, 0, 5, 200, 5));
		pending_q.push_back(make_item(glos_pkg::ACT_CAST, 200, 5, 0, 5));
		it.vd = 1'b0;
		pending_q.push_back(it);
		pending_q.push_back(make_item(glos_pkg::ACT_CAST, 0, 5, 200, 5));
		pending_q.push_back(make_item(glos_pkg::ACT_CAST, 2040, 10, 2100, 10));
		drain();

		set_map(13'd16, 13'd16, 13'd32);
		pending_q.push_back(make_item(glos_pkg::ACT_CAST, 100, 100, 100, 100));
		pending_q.push_back(make_item(glos_pkg::ACT_CAST, 0, 0, 65535, 65535));
		pending_q.push_back(make_item(glos_pkg::ACT_CAST, 65535, 65535, 0, 0));
		pending_q.push_back(make_item(glos_pkg::ACT_CAST, 65535, 0, 0, 65535));
		pending_q.push_back(make_item(glos_pkg::ACT_CAST, 0, 65535, 65535, 0));
		pending_q.push_back(make_item(glos_pkg::ACT_CAST, 500, 500, 10, 10));
		pending_q.push_back(make_item(glos_pkg::ACT_CAST, 30, 900, 30, 40));
		pending_q.push_back(make_item(glos_pkg::ACT_CAST, 500, 10, 530, 10));
		pending_q.push_back(make_item(glos_pkg::ACT_CAST, 10, 500, 10, 530));
		it = make_item(glos_pkg::ACT_WRITE, 0, 0, 0, 0);
		it.idx = 12'hFFF;
		it.vd = 1'b1;
		pending_q.push_back(it);
		pending_q.push_back(make_item(glos_pkg::ACT_CAST, 2000, 2000, 2047, 2047));
		drain();

		// long receiver hold-off while casts keep coming
		hold_req = 1;
		random_phase(100, 0, 0);
		random_phase(80, 60, 0);
		set_map(13'd1, 13'd1, 13'd1);
		random_phase(60, 0, 60);
		set_map(13'd0, 13'd64, 13'h1F20);
		random_phase(40, 32, 32);
		set_map(13'd64, 13'd0, 13'd0);
		random_phase(40, 0, 0);
		set_map(13'd4096, 13'd4096, 13'd255);
		random_phase(70, 32, 32);
		set_map(13'd4096, 13'd1, 13'd255);
		random_phase(60, 60, 0);
		set_map(13'h1FFF, 13'h1FFF, 13'd255);
		random_phase(60, 0, 60);
		set_map(13'd20, 13'd12, 13'd0);
		random_phase(60, 32, 32);

		repeat (300) @(posedge clk);
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
